// ----- hdl/a2ot_pkg.sv -----
// ----------------------------------------------------------------------------
// a2ot_pkg
// shared constants and types for the octant-reduced series arctangent
// ----------------------------------------------------------------------------
`default_nettype none

package a2ot_pkg;

   localparam int INPUT_WIDTH_DEF = 16;
   localparam int T_BITS    = 16;   // ratio t, unsigned q0.16
   localparam int COEF_BITS = 17;   // coefficients, unsigned q1.16
   localparam int P_BITS    = 21;   // horner partial sum, signed
   localparam int PHI_BITS  = 19;   // series result, signed q5.13
   localparam int ANG_BITS  = 20;   // angle before saturation
   localparam int OUT_BITS  = 16;
   localparam int NUM_COEFS = 5;
   localparam int HORNER_STEPS = 4;

   localparam logic signed [ANG_BITS-1:0] PI_Q13     = 20'sd25736;
   localparam logic signed [ANG_BITS-1:0] PI4_Q13    = 20'sd6434;
   localparam logic signed [ANG_BITS-1:0] TWO_PI_Q13 = 20'sd51472;

   localparam logic [COEF_BITS-1:0] COEF1_RST = 17'd65536;
   localparam logic [COEF_BITS-1:0] COEF3_RST = 17'd21845;
   localparam logic [COEF_BITS-1:0] COEF5_RST = 17'd13107;
   localparam logic [COEF_BITS-1:0] COEF7_RST = 17'd9362;
   localparam logic [COEF_BITS-1:0] COEF9_RST = 17'd7282;

   localparam logic [2:0] REG_COEF_1 = 3'd0;
   localparam logic [2:0] REG_COEF_3 = 3'd1;
   localparam logic [2:0] REG_COEF_5 = 3'd2;
   localparam logic [2:0] REG_COEF_7 = 3'd3;
   localparam logic [2:0] REG_COEF_9 = 3'd4;

   typedef struct packed {
      logic       valid;
      logic       zero_y;
      logic       x_neg;
      logic [2:0] oct;
   } ctx_type;

   typedef struct packed {
      ctx_type                  ctx;
      logic [T_BITS-1:0]        t;
      logic [T_BITS-1:0]        s;
      logic signed [P_BITS-1:0] p;
   } horner_type;

endpackage

`default_nettype wire

// ----- hdl/a2ot_div_cell.sv -----
// ----------------------------------------------------------------------------
// a2ot_div_cell
// one restoring-division cell, yields one quotient bit per beat
// ----------------------------------------------------------------------------
`default_nettype none

module a2ot_div_cell #(
   parameter int XW = a2ot_pkg::INPUT_WIDTH_DEF + 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  a2ot_pkg::ctx_type            ctx_d,
   input  wire [XW-1:0]                 x_d,
   input  wire [XW-1:0]                 rem_d,
   input  wire [a2ot_pkg::T_BITS-1:0]   quo_d,
   output a2ot_pkg::ctx_type            ctx_q,
   output logic [XW-1:0]                x_q,
   output logic [XW-1:0]                rem_q,
   output logic [a2ot_pkg::T_BITS-1:0]  quo_q
);

   a2ot_pkg::ctx_type               ctx_ff;
   logic [XW-1:0]                   x_ff, rem_ff, rem_in;
   logic [a2ot_pkg::T_BITS-1:0]     quo_ff;
   logic [XW:0]                     rem2, diff;
   logic                            take;

   always_comb begin
      rem2   = {rem_d, 1'b0};
      diff   = rem2 - {1'b0, x_d};
      take   = (rem2 >= {1'b0, x_d});
      // remainder stays below x, so it fits back in xw bits
      rem_in = take ? diff[XW-1:0] : rem2[XW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
      end else if (en) begin
         ctx_ff <= ctx_d;
      end
      if (en) begin
         x_ff   <= x_d;
         rem_ff <= rem_in;
         quo_ff <= {quo_d[a2ot_pkg::T_BITS-2:0], take};
      end
   end

   assign ctx_q = ctx_ff;
   assign x_q   = x_ff;
   assign rem_q = rem_ff;
   assign quo_q = quo_ff;

endmodule

`default_nettype wire

// ----- hdl/a2ot_horner_cell.sv -----
// ----------------------------------------------------------------------------
// a2ot_horner_cell
// one horner step: p = c - floor(s * p / 2^16)
// ----------------------------------------------------------------------------
`default_nettype none

module a2ot_horner_cell (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             en,
   input  wire [a2ot_pkg::COEF_BITS-1:0]   coef,
   input  a2ot_pkg::horner_type            d,
   output a2ot_pkg::horner_type            q
);

   localparam int PW = a2ot_pkg::T_BITS + 1 + a2ot_pkg::P_BITS;
   localparam int SW = PW - a2ot_pkg::T_BITS;

   a2ot_pkg::horner_type   q_ff, q_in;
   logic signed [PW-1:0]   prod;
   logic signed [SW-1:0]   diff;

   always_comb begin
      prod = $signed({1'b0, d.s}) * d.p;
      diff = $signed({{(SW-a2ot_pkg::COEF_BITS){1'b0}}, coef})
             - prod[PW-1:a2ot_pkg::T_BITS];
      q_in   = d;
      q_in.p = diff[a2ot_pkg::P_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.ctx <= '0;
      end else if (en) begin
         q_ff.ctx <= q_in.ctx;
      end
      if (en) begin
         q_ff.t <= q_in.t;
         q_ff.s <= q_in.s;
         q_ff.p <= q_in.p;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ----- hdl/atan2_octant_taylor.sv -----
// ----------------------------------------------------------------------------
// atan2_octant_taylor
// four-quadrant arctangent: octant reduction, bit-serial divider chain,
// horner series chain, octant offset and wrap
// ----------------------------------------------------------------------------
//  channel  | ports                              | direction
//  req      | req_valid/ready, req_x_in, req_y_in | in
//  rsp      | rsp_valid/ready, rsp_angle_out      | out
//  csr      | csr_we, csr_index, csr_wdata        | in, write only
//
//  one beat accepted per cycle; stages in order: reduction, 16 divider
//  cells, square, 4 horner cells, final product, output register
//  the whole chain advances together whenever the output register is empty
//  or being taken; a stall on rsp freezes every cell
//  reset clears valid bits and loads the nominal coefficients
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_octant_taylor #(
   parameter int INPUT_WIDTH = a2ot_pkg::INPUT_WIDTH_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire signed [INPUT_WIDTH-1:0]          req_x_in,
   input  wire signed [INPUT_WIDTH-1:0]          req_y_in,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic signed [a2ot_pkg::OUT_BITS-1:0]  rsp_angle_out,
   input  wire                                   csr_we,
   input  wire [2:0]                             csr_index,
   input  wire [a2ot_pkg::COEF_BITS-1:0]         csr_wdata
);

   localparam int XW = INPUT_WIDTH + 1;   // rotated magnitudes, unsigned
   localparam int RW = INPUT_WIDTH + 2;   // working width during rotation
   localparam int TB = a2ot_pkg::T_BITS;
   localparam int NH = a2ot_pkg::HORNER_STEPS;
   localparam int MW = TB + 1 + a2ot_pkg::P_BITS;

   // coefficient registers
   logic [a2ot_pkg::COEF_BITS-1:0] coef1_ff, coef3_ff, coef5_ff, coef7_ff, coef9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef1_ff <= a2ot_pkg::COEF1_RST;
         coef3_ff <= a2ot_pkg::COEF3_RST;
         coef5_ff <= a2ot_pkg::COEF5_RST;
         coef7_ff <= a2ot_pkg::COEF7_RST;
         coef9_ff <= a2ot_pkg::COEF9_RST;
      end else if (csr_we) begin
         case (csr_index)
            a2ot_pkg::REG_COEF_1: coef1_ff <= csr_wdata;
            a2ot_pkg::REG_COEF_3: coef3_ff <= csr_wdata;
            a2ot_pkg::REG_COEF_5: coef5_ff <= csr_wdata;
            a2ot_pkg::REG_COEF_7: coef7_ff <= csr_wdata;
            a2ot_pkg::REG_COEF_9: coef9_ff <= csr_wdata;
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   // global advance: chain moves when output slot is free or being taken
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // octant reduction
   logic signed [RW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
   logic [2:0]           oct_r;
   a2ot_pkg::ctx_type    red_ctx_in, red_ctx_ff;
   logic [XW-1:0]        red_x_ff, red_y_ff;

   always_comb begin
      x0 = RW'(req_x_in);
      y0 = RW'(req_y_in);
      oct_r = 3'd0;
      if (y0 < 0) begin
         x1 = -x0;
         y1 = -y0;
         oct_r[2] = 1'b1;
      end else begin
         x1 = x0;
         y1 = y0;
      end
      if (x1 <= 0) begin
         x2 = y1;
         y2 = -x1;
         oct_r[1] = 1'b1;
      end else begin
         x2 = x1;
         y2 = y1;
      end
      // 45 degree step grows by one bit
      if (x2 <= y2) begin
         x3 = x2 + y2;
         y3 = y2 - x2;
         oct_r[0] = 1'b1;
      end else begin
         x3 = x2;
         y3 = y2;
      end
      red_ctx_in.valid  = req_valid;
      red_ctx_in.zero_y = (req_y_in == '0);
      red_ctx_in.x_neg  = req_x_in[INPUT_WIDTH-1];
      red_ctx_in.oct    = oct_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ctx_ff <= '0;
      end else if (adv) begin
         red_ctx_ff <= red_ctx_in;
      end
      if (adv) begin
         // for zero-y beats x may be 0; the divider output is then ignored
         red_x_ff <= x3[XW-1:0];
         red_y_ff <= y3[XW-1:0];
      end
   end

   // divider chain, one quotient bit per cell
   a2ot_pkg::ctx_type dv_ctx [TB+1];
   logic [XW-1:0]     dv_x   [TB+1];
   logic [XW-1:0]     dv_rem [TB+1];
   logic [TB-1:0]     dv_quo [TB+1];

   assign dv_ctx[0] = red_ctx_ff;
   assign dv_x[0]   = red_x_ff;
   assign dv_rem[0] = red_y_ff;
   assign dv_quo[0] = '0;

   for (genvar i = 0; i < TB; i++) begin : g_div
      a2ot_div_cell #(.XW(XW)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .ctx_d (dv_ctx[i]),
         .x_d   (dv_x[i]),
         .rem_d (dv_rem[i]),
         .quo_d (dv_quo[i]),
         .ctx_q (dv_ctx[i+1]),
         .x_q   (dv_x[i+1]),
         .rem_q (dv_rem[i+1]),
         .quo_q (dv_quo[i+1])
      );
   end

   // square stage, seeds horner with c9
   logic [2*TB-1:0]      sq;
   a2ot_pkg::horner_type hn [NH+1];
   a2ot_pkg::horner_type sq_ff;

   assign sq = dv_quo[TB] * dv_quo[TB];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.ctx <= '0;
      end else if (adv) begin
         sq_ff.ctx <= dv_ctx[TB];
      end
      if (adv) begin
         sq_ff.t <= dv_quo[TB];
         sq_ff.s <= sq[2*TB-1:TB];
         sq_ff.p <= $signed({{(a2ot_pkg::P_BITS-a2ot_pkg::COEF_BITS){1'b0}}, coef9_ff});
      end
   end

   assign hn[0] = sq_ff;

   logic [a2ot_pkg::COEF_BITS-1:0] hcoef [NH];
   assign hcoef[0] = coef7_ff;
   assign hcoef[1] = coef5_ff;
   assign hcoef[2] = coef3_ff;
   assign hcoef[3] = coef1_ff;

   for (genvar k = 0; k < NH; k++) begin : g_horner
      a2ot_horner_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .coef  (hcoef[k]),
         .d     (hn[k]),
         .q     (hn[k+1])
      );
   end

   // final product t * p, floored to q5.13
   logic signed [MW-1:0]                 fin_prod;
   logic signed [a2ot_pkg::PHI_BITS-1:0] phi_ff;
   a2ot_pkg::ctx_type                    phi_ctx_ff;

   assign fin_prod = $signed({1'b0, hn[NH].t}) * hn[NH].p;

   always_ff @(posedge clock) begin
      if (reset) begin
         phi_ctx_ff <= '0;
      end else if (adv) begin
         phi_ctx_ff <= hn[NH].ctx;
      end
      if (adv) begin
         phi_ff <= fin_prod[MW-1:TB+3];
      end
   end

   // octant offset, wrap and saturation
   logic signed [a2ot_pkg::ANG_BITS-1:0] off, ang, ang_w, ang_s;
   logic signed [a2ot_pkg::OUT_BITS-1:0] angle_in, angle_ff;

   always_comb begin
      case (phi_ctx_ff.oct)
         3'd0:    off = '0;
         3'd1:    off = a2ot_pkg::PI4_Q13;
         3'd2:    off = a2ot_pkg::ANG_BITS'(a2ot_pkg::PI4_Q13 * 2);
         3'd3:    off = a2ot_pkg::ANG_BITS'(a2ot_pkg::PI4_Q13 * 3);
         3'd4:    off = a2ot_pkg::ANG_BITS'(a2ot_pkg::PI4_Q13 * 4);
         3'd5:    off = a2ot_pkg::ANG_BITS'(a2ot_pkg::PI4_Q13 * 5);
         3'd6:    off = a2ot_pkg::ANG_BITS'(a2ot_pkg::PI4_Q13 * 6);
         default: off = a2ot_pkg::ANG_BITS'(a2ot_pkg::PI4_Q13 * 7);
      endcase
      ang   = a2ot_pkg::ANG_BITS'(phi_ff) + off;
      ang_w = (ang > a2ot_pkg::PI_Q13) ? ang - a2ot_pkg::TWO_PI_Q13 : ang;
      if (phi_ctx_ff.zero_y) begin
         ang_s = phi_ctx_ff.x_neg ? a2ot_pkg::PI_Q13 : '0;
      end else if (ang_w > a2ot_pkg::PI_Q13) begin
         ang_s = a2ot_pkg::PI_Q13;
      end else if (ang_w < -a2ot_pkg::PI_Q13) begin
         ang_s = -a2ot_pkg::PI_Q13;
      end else begin
         ang_s = ang_w;
      end
      angle_in = ang_s[a2ot_pkg::OUT_BITS-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= phi_ctx_ff.valid;
      end
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_out = angle_ff;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives vectors into the octant-reduced series arctangent, predicts every
// angle from its own fixed-point model and compares beat by beat
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 24;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 1550;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [15:0]             req_x_in = '0;
   logic signed [15:0]             req_y_in = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [15:0]             rsp_angle_out;
   logic                           csr_we = 1'b0;
   logic [2:0]                     csr_index = '0;
   logic [a2ot_pkg::COEF_BITS-1:0] csr_wdata = '0;

   atan2_octant_taylor u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_in(req_x_in), .req_y_in(req_y_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_angle_out(rsp_angle_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor copy of the coefficient registers
   logic [a2ot_pkg::COEF_BITS-1:0] coef [a2ot_pkg::NUM_COEFS];

   logic signed [15:0] angle_q [$];
   int   n_err = 0;
   int   idle_cycles = 0;
   bit   quiet_tail = 0;     // no idling near the end
   bit   hold_rsp = 0;       // long receiver hold-off

   // floor(v / 2^n) for signed 64-bit values
   function automatic longint fl_shr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic logic signed [15:0] predict_angle(logic signed [15:0] xi,
                                                        logic signed [15:0] yi);
      longint x, y, tmp, t, s, p, phi, ang, oct;
      x = xi;
      y = yi;
      oct = 0;
      if (y == 0) begin
         ang = (x >= 0) ? 0 : 25736;
      end else begin
         if (y < 0) begin
            x = -x; y = -y; oct += 4;
         end
         if (x <= 0) begin
            tmp = -x; x = y; y = tmp; oct += 2;
         end
         if (x <= y) begin
            tmp = y - x; x = x + y; y = tmp; oct += 1;
         end
         t = (y << 16) / x;
         if (t > 65535) t = 65535;
         s = (t * t) >> 16;
         p = coef[4];
         p = longint'(coef[3]) - fl_shr(s * p, 16);
         p = longint'(coef[2]) - fl_shr(s * p, 16);
         p = longint'(coef[1]) - fl_shr(s * p, 16);
         p = longint'(coef[0]) - fl_shr(s * p, 16);
         phi = fl_shr(fl_shr(t * p, 16), 3);
         ang = phi + oct * 6434;
         if (ang > 25736) ang -= 51472;
      end
      if (ang > 25736) ang = 25736;
      if (ang < -25736) ang = -25736;
      return ang[15:0];
   endfunction

   // register write while idle; index may be out of range (ignored)
   task automatic write_coef(logic [2:0] idx, logic [a2ot_pkg::COEF_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx < a2ot_pkg::NUM_COEFS) coef[idx] = val;
   endtask

   // wait for every outstanding angle, then let the pipe drain
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (angle_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // offer one beat, optionally preceded by a sender gap
   task automatic send_vec(logic signed [15:0] xv, logic signed [15:0] yv,
                           bit may_idle);
      if (may_idle && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_in  <= xv;
      req_y_in  <= yv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      angle_q.push_back(predict_angle(xv, yv));
      @(negedge clock);
   endtask

   // random vector, weighted toward axes, diagonals, extremes and small values
   function automatic logic [31:0] rand_vec();
      logic signed [15:0] a, b;
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(0, 9))
         0: b = 0;
         1: a = 0;
         2: b = a;
         3: b = -a;
         4: a = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
         5: begin
            a = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            b = $signed(16'($urandom_range(0, 15))) - 16'sd8;
         end
         default: ;
      endcase
      return {a, b};
   endfunction

   // receiver: random bursts of stall, or a long hold-off on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // result check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (angle_q.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected angle beat %0d", rsp_angle_out);
         end else begin
            if (rsp_angle_out !== angle_q[0]) begin
               n_err++;
               if (n_err <= 10)
                  $display("angle mismatch: expected %0d actual %0d",
                           angle_q[0], rsp_angle_out);
            end
            void'(angle_q.pop_front());
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_rsp)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // directed table: x, y, expected angle (check flag = 1 if typed in)
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] ang;
      bit                 typed;
   } vec_row_type;

   vec_row_type dir_tab [21] = '{
      '{16'sd0,      16'sd0,      16'sd0,     1},  // origin
      '{16'sd100,    16'sd0,      16'sd0,     1},  // positive x axis
      '{-16'sd100,   16'sd0,      16'sd25736, 1},  // negative x axis gives pi
      '{16'sh8000,   16'sd0,      16'sd25736, 1},  // most negative x, zero y
      '{16'sh7fff,   16'sd0,      16'sd0,     1},
      '{16'sd0,      16'sd1,      16'sd0,     0},
      '{16'sd0,      -16'sd1,     16'sd0,     0},
      '{16'sd1,      16'sd1,      16'sd0,     0},  // diagonal
      '{-16'sd1,     -16'sd1,     16'sd0,     0},
      '{16'sh8000,   16'sh8000,   16'sd0,     0},  // most negative both
      '{16'sh7fff,   16'sh8000,   16'sd0,     0},
      '{16'sh8000,   16'sh7fff,   16'sd0,     0},
      '{16'sh7fff,   16'sh7fff,   16'sd0,     0},
      '{16'sh8000,   16'sd1,      16'sd0,     0},  // just below pi
      '{16'sh8000,   -16'sd1,     16'sd0,     0},  // just above minus pi
      '{16'sh7fff,   16'sd1,      16'sd0,     0},
      '{16'sd0,      16'sh8000,   16'sd0,     0},
      '{16'sd3,      16'sd7,      16'sd0,     0},
      '{-16'sd7,     16'sd3,      16'sd0,     0},
      '{-16'sd3,     -16'sd7,     16'sd0,     0},
      '{16'sd7,      -16'sd3,     16'sd0,     0}
   };

   // coefficient settings walked between phases, extremes among them
   logic [a2ot_pkg::COEF_BITS-1:0] coef_sets [4][a2ot_pkg::NUM_COEFS] = '{
      '{17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff},
      '{17'h00000, 17'h00000, 17'h00000, 17'h00000, 17'h00000},
      '{17'h1ffff, 17'h00000, 17'h1ffff, 17'h00000, 17'h1ffff},
      '{a2ot_pkg::COEF1_RST, a2ot_pkg::COEF3_RST, a2ot_pkg::COEF5_RST,
        a2ot_pkg::COEF7_RST, a2ot_pkg::COEF9_RST}
   };

   initial begin
      logic [31:0] v;
      int ph, k, i;
      coef[0] = a2ot_pkg::COEF1_RST; coef[1] = a2ot_pkg::COEF3_RST;
      coef[2] = a2ot_pkg::COEF5_RST; coef[3] = a2ot_pkg::COEF7_RST;
      coef[4] = a2ot_pkg::COEF9_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows at reset coefficients
      foreach (dir_tab[r]) begin
         if (dir_tab[r].typed) begin
            send_vec(dir_tab[r].x, dir_tab[r].y, 0);
            angle_q[angle_q.size()-1] = dir_tab[r].ang;
         end else begin
            send_vec(dir_tab[r].x, dir_tab[r].y, 1);
         end
      end

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1;
      fork
         begin
            repeat (60) begin
               v = rand_vec();
               send_vec(v[31:16], v[15:0], 0);
            end
         end
         begin
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end
      join
      drain_pipe();

      // unknown register index must be ignored
      write_coef(3'd5, 17'h0);
      write_coef(3'd7, 17'h1ffff);

      for (ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            drain_pipe();   // sender pauses until everything is back
            for (k = 0; k < a2ot_pkg::NUM_COEFS; k++) begin
               if (ph == 4) write_coef(k[2:0], 17'($urandom_range(0, 131071)));
               else write_coef(k[2:0], coef_sets[ph-1][k]);
            end
         end
         for (i = 0; i < N_RANDOM / 5; i++) begin
            if (ph == 4 && i > N_RANDOM / 5 - 80) quiet_tail = 1;
            v = rand_vec();
            send_vec(v[31:16], v[15:0], 1);
         end
      end

      drain_pipe();
      if (n_err == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
